/* hw/rtl/fpcc_pkg.sv */
// ----------------------------------------------------------------------------
// fpcc_pkg: shared types and constants of the flight phase / cutdown controller
// Phase codes, item kinds, register indexes, queue payloads, saturation helper.
// ----------------------------------------------------------------------------
package fpcc_pkg;

  localparam int unsigned AltW     = 24;
  localparam int unsigned RiseW    = 20;
  localparam int unsigned MinAltW  = 20;
  localparam int unsigned CutW     = 23;
  localparam int unsigned BandW    = 20;
  localparam int unsigned CfgDataW = 23;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [RiseW-1:0]   RiseReset   = RiseW'(1000);
  localparam logic [MinAltW-1:0] MinAltReset = MinAltW'(6000);
  localparam logic [CutW-1:0]    CutReset    = CutW'(30000);
  localparam logic [BandW-1:0]   BandReset   = BandW'(100);

  typedef enum logic [2:0] {
    PH_REF       = 3'd0,
    PH_FILL      = 3'd1,
    PH_PRELAUNCH = 3'd2,
    PH_ASCENT    = 3'd3,
    PH_DESCENT   = 3'd4,
    PH_LANDED    = 3'd5
  } phase_e;

  // What the front decided a sample is.
  typedef enum logic [1:0] {
    K_REF       = 2'd0,
    K_FILL      = 2'd1,
    K_FILL_LAST = 2'd2,
    K_RUN       = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    FM_REF  = 2'd0,
    FM_FILL = 2'd1,
    FM_RUN  = 2'd2
  } fmode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LIFTOFF_RISE    = 2'd0,
    CFG_LIFTOFF_MIN_ALT = 2'd1,
    CFG_CUTDOWN_ALT     = 2'd2,
    CFG_LANDED_BAND     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                we;
    cfg_idx_e            idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    kind_e                  kind;
    logic signed [AltW-1:0] rel;
    logic                   valid;
  } mid_item_t;

  typedef struct packed {
    phase_e                 phase;
    logic signed [AltW-1:0] rel;
    logic signed [AltW-1:0] change;
    logic                   fire;
    logic                   fault;
  } res_item_t;

  // Clamp a one-bit-grown difference back to AltW signed.
  function automatic logic [AltW-1:0] sat_alt(input logic [AltW:0] v);
    logic [AltW-1:0] r;
    if (v[AltW] != v[AltW-1]) begin
      r = v[AltW] ? {1'b1, {(AltW-1){1'b0}}} : {1'b0, {(AltW-1){1'b1}}};
    end else begin
      r = v[AltW-1:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/flight_phase_cutdown_controller_core.sv */
// ----------------------------------------------------------------------------
// flight_phase_cutdown_controller_core: balloon flight phase and cutdown logic
// Tracks reference, window fill and flight phases from altitude samples.
// ----------------------------------------------------------------------------
// Usage: push one altitude sample (cm) per request; every request returns
// exactly one result on the result queue, in order. The first sample after
// reset is the ground reference, the next WINDOW fill the altitude ring, and
// from then on the phase runs prelaunch, ascent, descent, landed. Throughput
// is one request per clock when results are popped as fast; the figure is set
// by the ring RAM, which takes one write of the new entry and one read of the
// oldest entry per sample. A result passes the intake queue, the ring access
// into the decision stage and the write of the result queue, in that order,
// before it reaches the head, and a full result queue can hold it back. The
// ring needs no clearing after reset: no entry is read before the fill
// phase has written it. Threshold registers may only be written while no
// request is in flight; writes take effect at once.
// ----------------------------------------------------------------------------
module flight_phase_cutdown_controller_core import fpcc_pkg::*; #(
  parameter int unsigned WINDOW = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // sample requests
  input  logic                   push,
  output logic                   full,
  input  logic signed [AltW-1:0] altitude_cm_i,
  input  logic                   sample_valid_i,
  // results
  output logic                   empty,
  input  logic                   pop,
  output logic [2:0]             phase_o,
  output logic signed [AltW-1:0] relative_alt_cm_o,
  output logic signed [AltW-1:0] window_change_cm_o,
  output logic                   cutdown_fire_o,
  output logic                   sensor_fault_o,
  // threshold registers
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_idx_i,
  input  logic [CfgDataW-1:0]    cfg_data_i
);

  // Two entries each side are enough for full rate.
  localparam int unsigned MidDepth = 2;
  localparam int unsigned ResDepth = 2;

  mid_item_t mid_in, mid_out;
  logic      mid_push, mid_full, mid_pop, mid_empty;
  res_item_t res_in, res_head;
  logic      res_push, res_full;
  cfg_wr_t   cfg_wr;

  assign cfg_wr.we   = cfg_we_i;
  assign cfg_wr.idx  = cfg_idx_e'(cfg_idx_i);
  assign cfg_wr.data = cfg_data_i;

  // Front: reference capture, relative altitude, sample classification.
  fpcc_front #(
    .WINDOW(WINDOW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .altitude_cm_i (altitude_cm_i),
    .sample_valid_i(sample_valid_i),
    .full_o        (full),
    .mid_push_o    (mid_push),
    .mid_item_o    (mid_in),
    .mid_full_i    (mid_full)
  );

  // Decoupling queue between front and back.
  fpcc_fifo #(
    .WIDTH($bits(mid_item_t)),
    .DEPTH(MidDepth)
  ) u_mid_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (mid_push),
    .data_i (mid_in),
    .full_o (mid_full),
    .pop_i  (mid_pop),
    .data_o (mid_out),
    .empty_o(mid_empty)
  );

  // Back: ring update, window change, phase transitions, cutdown.
  fpcc_back #(
    .WINDOW(WINDOW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mid_empty_i(mid_empty),
    .mid_item_i (mid_out),
    .mid_pop_o  (mid_pop),
    .cfg_wr_i   (cfg_wr),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_item_o (res_in)
  );

  // Result queue; its head drives the result ports.
  fpcc_fifo #(
    .WIDTH($bits(res_item_t)),
    .DEPTH(ResDepth)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_head),
    .empty_o(empty)
  );

  assign phase_o            = res_head.phase;
  assign relative_alt_cm_o  = res_head.rel;
  assign window_change_cm_o = res_head.change;
  assign cutdown_fire_o     = res_head.fire;
  assign sensor_fault_o     = res_head.fault;

endmodule

/* hw/rtl/fpcc_ram.sv */
// ----------------------------------------------------------------------------
// fpcc_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fpcc_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 20
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/fpcc_fifo.sv */
// ----------------------------------------------------------------------------
// fpcc_fifo: small register queue
// Push/full on one side, pop/empty on the other; head shown while not empty.
// ----------------------------------------------------------------------------
module fpcc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* hw/rtl/fpcc_front.sv */
// ----------------------------------------------------------------------------
// fpcc_front: sample intake
// Captures the ground reference, forms relative altitude, tags each sample.
// ----------------------------------------------------------------------------
module fpcc_front import fpcc_pkg::*; #(
  parameter int unsigned WINDOW = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic signed [AltW-1:0] altitude_cm_i,
  input  logic                   sample_valid_i,
  output logic                   full_o,
  output logic                   mid_push_o,
  output mid_item_t              mid_item_o,
  input  logic                   mid_full_i
);

  localparam int unsigned CntW = $clog2(WINDOW);
  localparam logic [CntW-1:0] LastFill = CntW'(WINDOW - 1);

  fmode_e                 mode_q, mode_d;
  logic [CntW-1:0]        fill_q, fill_d;
  logic signed [AltW-1:0] ref_q, ref_d;
  logic                   accept;
  logic [AltW:0]          diff;

  assign accept = push_i & ~mid_full_i;
  assign full_o = mid_full_i;
  assign diff   = {altitude_cm_i[AltW-1], altitude_cm_i} - {ref_q[AltW-1], ref_q};

  // next state
  always_comb begin
    mode_d = mode_q;
    fill_d = fill_q;
    ref_d  = ref_q;
    if (accept) begin
      unique case (mode_q)
        FM_REF: begin
          ref_d  = altitude_cm_i;
          mode_d = FM_FILL;
        end
        FM_FILL: begin
          if (fill_q == LastFill) begin
            mode_d = FM_RUN;
          end else begin
            fill_d = fill_q + 1'b1;
          end
        end
        FM_RUN: begin
          mode_d = FM_RUN;
        end
        default: begin
          mode_d = FM_REF;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    mid_push_o       = accept;
    mid_item_o.valid = sample_valid_i;
    mid_item_o.rel   = sat_alt(diff);
    unique case (mode_q)
      FM_REF: begin
        mid_item_o.kind = K_REF;
        mid_item_o.rel  = '0;
      end
      FM_FILL: begin
        mid_item_o.kind = (fill_q == LastFill) ? K_FILL_LAST : K_FILL;
      end
      default: begin
        mid_item_o.kind = K_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= FM_REF;
      fill_q <= '0;
      ref_q  <= '0;
    end else begin
      mode_q <= mode_d;
      fill_q <= fill_d;
      ref_q  <= ref_d;
    end
  end

endmodule

/* hw/rtl/fpcc_back.sv */
// ----------------------------------------------------------------------------
// fpcc_back: window ring and phase logic
// Stage A writes the ring and reads the oldest entry; stage B decides phase.
// ----------------------------------------------------------------------------
module fpcc_back import fpcc_pkg::*; #(
  parameter int unsigned WINDOW = 20
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      mid_empty_i,
  input  mid_item_t mid_item_i,
  output logic      mid_pop_o,
  input  cfg_wr_t   cfg_wr_i,
  input  logic      res_full_i,
  output logic      res_push_o,
  output res_item_t res_item_o
);

  localparam int unsigned SlotW = $clog2(WINDOW);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(WINDOW - 1);

  logic [RiseW-1:0]   rise_q, rise_d;
  logic [MinAltW-1:0] minalt_q, minalt_d;
  logic [CutW-1:0]    cut_q, cut_d;
  logic [BandW-1:0]   band_q, band_d;

  logic [SlotW-1:0] slot_q, slot_d, old_slot;
  logic             a_fire, b_done, ram_we, ram_re;
  logic [AltW-1:0]  ram_rdata;

  logic                   b_vld_q, b_vld_d;
  kind_e                  b_kind_q;
  logic signed [AltW-1:0] b_rel_q;
  logic                   b_valid_q;

  phase_e phase_q, phase_d, res_phase;

  logic [AltW:0]          chg_wide, chg_ext, mag;
  logic signed [AltW-1:0] change;
  logic                   rise_hit, minalt_hit, cut_hit, land_hit, chg_pos;

  // ---- configuration ----
  always_comb begin
    rise_d   = rise_q;
    minalt_d = minalt_q;
    cut_d    = cut_q;
    band_d   = band_q;
    if (cfg_wr_i.we) begin
      case (cfg_wr_i.idx)
        CFG_LIFTOFF_RISE:    rise_d   = cfg_wr_i.data[RiseW-1:0];
        CFG_LIFTOFF_MIN_ALT: minalt_d = cfg_wr_i.data[MinAltW-1:0];
        CFG_CUTDOWN_ALT:     cut_d    = cfg_wr_i.data[CutW-1:0];
        CFG_LANDED_BAND:     band_d   = cfg_wr_i.data[BandW-1:0];
        default: ;
      endcase
    end
  end

  // ---- stage A: ring access ----
  assign b_done    = b_vld_q & ~res_full_i;
  assign a_fire    = ~mid_empty_i & (~b_vld_q | ~res_full_i);
  assign mid_pop_o = a_fire;
  assign ram_we    = a_fire & (mid_item_i.kind != K_REF);
  assign ram_re    = a_fire & (mid_item_i.kind == K_RUN);
  assign old_slot  = (slot_q == LastSlot) ? '0 : slot_q + 1'b1;
  assign slot_d    = ram_we ? old_slot : slot_q;
  assign b_vld_d   = a_fire ? 1'b1 : (b_done ? 1'b0 : b_vld_q);

  fpcc_ram #(
    .WIDTH(AltW),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(slot_q),
    .wdata_i(mid_item_i.rel),
    .re_i   (ram_re),
    .raddr_i(old_slot),
    .rdata_o(ram_rdata)
  );

  // ---- stage B: change and thresholds ----
  assign chg_wide   = {b_rel_q[AltW-1], b_rel_q} - {ram_rdata[AltW-1], ram_rdata};
  assign change     = sat_alt(chg_wide);
  assign chg_ext    = {change[AltW-1], change};
  assign mag        = change[AltW-1] ? (~chg_ext + 1'b1) : chg_ext;
  assign chg_pos    = ~change[AltW-1] & (change != '0);
  assign rise_hit   = change > $signed({1'b0, rise_q});
  assign minalt_hit = b_rel_q > $signed({1'b0, minalt_q});
  assign cut_hit    = b_rel_q > $signed({1'b0, cut_q});
  assign land_hit   = mag < (AltW + 1)'(band_q);

  // next phase
  always_comb begin
    res_phase = phase_q;
    unique case (b_kind_q) inside
      K_REF, K_FILL: res_phase = PH_FILL;
      K_FILL_LAST:   res_phase = PH_PRELAUNCH;
      default: begin
        unique case (phase_q)
          PH_PRELAUNCH: begin
            if (rise_hit || (minalt_hit && chg_pos)) res_phase = PH_ASCENT;
          end
          PH_ASCENT: begin
            if (cut_hit) res_phase = PH_DESCENT;
          end
          PH_DESCENT: begin
            if (land_hit) res_phase = PH_LANDED;
          end
          default: res_phase = PH_LANDED;
        endcase
      end
    endcase
    phase_d = b_done ? res_phase : phase_q;
  end

  // result fields
  always_comb begin
    res_push_o        = b_done;
    res_item_o.phase  = res_phase;
    res_item_o.rel    = b_rel_q;
    res_item_o.change = (b_kind_q == K_RUN) ? change : '0;
    res_item_o.fire   = (b_kind_q == K_RUN) & (phase_q == PH_ASCENT) & cut_hit;
    res_item_o.fault  = (b_kind_q == K_RUN) & ~b_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_q   <= RiseReset;
      minalt_q <= MinAltReset;
      cut_q    <= CutReset;
      band_q   <= BandReset;
      slot_q   <= '0;
      b_vld_q  <= 1'b0;
      phase_q  <= PH_REF;
    end else begin
      rise_q   <= rise_d;
      minalt_q <= minalt_d;
      cut_q    <= cut_d;
      band_q   <= band_d;
      slot_q   <= slot_d;
      b_vld_q  <= b_vld_d;
      phase_q  <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      b_kind_q  <= mid_item_i.kind;
      b_rel_q   <= mid_item_i.rel;
      b_valid_q <= mid_item_i.valid;
    end
  end

`ifndef SYNTHESIS
  a_landed_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_LANDED |=> phase_q == PH_LANDED)
    else $error("landed phase left");

  a_fire_from_ascent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_item_o.fire) |-> (phase_q == PH_ASCENT && res_phase == PH_DESCENT))
    else $error("cutdown fired outside ascent to descent");

  a_stall_holds_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_vld_q && b_kind_q == K_RUN && res_full_i) |=> $stable(ram_rdata))
    else $error("ring read data lost during stall");

  a_fault_only_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_item_o.fault) |-> (res_phase != PH_REF && res_phase != PH_FILL))
    else $error("sensor fault outside flight phases");
`endif

endmodule
